// ----- rtl/grars_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grars_pkg
// Shared constants for the grid range-add / range-sum core: field widths,
// parameter defaults, item function codes and register indexes.
// ----------------------------------------------------------------------------
package grars_pkg;

  // parameter defaults
  localparam int MAX_ROWS_DEF  = 256;
  localparam int MAX_COLS_DEF  = 256;
  localparam int SUM_WIDTH_DEF = 64;

  // fixed field widths
  localparam int COORD_W  = 9;
  localparam int ADDEND_W = 32;
  localparam int TOTAL_W  = 64;
  localparam int FUNC_W   = 2;
  localparam int HALF_W   = 32;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SUM   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

endpackage

// ----- rtl/grars_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grars_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grars_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/grid_range_add_range_sum_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_range_add_range_sum_core
// Integer grid with rectangle add, rectangle sum and clear, held as a
// two-dimensional binary indexed tree of corner coefficients in one RAM.
// ----------------------------------------------------------------------------
// Items are handled one at a time. The four coefficient trees share one RAM
// word per node, so every tree node costs one RAM access pair. An add walks
// four corners, each a setup (S_CPREP, S_CMUL) followed by a read and a
// write back per node, up to (log2(MAX_ROWS)+1)*(log2(MAX_COLS)+1) nodes
// per corner. A sum walks four prefixes, each a setup (S_CPREP) followed by
// a read and an accumulate per node, up to 8*8 nodes per prefix at the
// default size, then weights the coefficients on a shared 32-bit multiplier.
// A rejected item goes straight to S_DONE. After reset, and for a clear
// item, the RAM is swept one word per cycle, all MAX_ROWS*MAX_COLS words,
// during which no item is taken; configuration writes are taken at all
// times. A finished result waits in an output register, so the next item
// is taken while the previous result is still pending.
// ----------------------------------------------------------------------------
module grid_range_add_range_sum_core #(
  parameter int MAX_ROWS  = grars_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = grars_pkg::MAX_COLS_DEF,
  parameter int SUM_WIDTH = grars_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [grars_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grars_pkg::COORD_W-1:0]       cfg_wdata,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [grars_pkg::FUNC_W-1:0]        in_func,
  input  logic [grars_pkg::COORD_W-1:0]       in_row_low,
  input  logic [grars_pkg::COORD_W-1:0]       in_col_low,
  input  logic [grars_pkg::COORD_W-1:0]       in_row_high,
  input  logic [grars_pkg::COORD_W-1:0]       in_col_high,
  input  logic signed [grars_pkg::ADDEND_W-1:0] in_addend,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [grars_pkg::TOTAL_W-1:0] out_total,
  output logic                                out_status
);

  localparam int CDW   = grars_pkg::COORD_W;
  localparam int SW    = SUM_WIDTH;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RIW   = RW + 1;
  localparam int CIW   = CW + 1;
  localparam int FW    = RW + CW;
  localparam int XW    = grars_pkg::ADDEND_W + 1;
  localparam int PXW   = XW + FW + 1;
  localparam int HW    = grars_pkg::HALF_W;
  localparam int TW    = grars_pkg::TOTAL_W;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = 4 * SW;

  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [RIW-1:0] ROW_LIM   = RIW'(MAX_ROWS);
  localparam logic [CIW-1:0] COL_LIM   = CIW'(MAX_COLS);
  localparam logic [CDW-1:0] ROWS_RST  = CDW'((MAX_ROWS < 256) ? MAX_ROWS : 256);
  localparam logic [CDW-1:0] COLS_RST  = CDW'((MAX_COLS < 256) ? MAX_COLS : 256);

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CPREP = 4'd2;
  localparam logic [3:0] S_CMUL  = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_AWR   = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PACC  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_MACC  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // control registers
  logic [3:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r;
  logic           clr_item_r;
  logic [CDW-1:0] rows_r, cols_r;
  logic           out_valid_r;

  // payload registers
  logic                  is_sum_r;
  logic [CDW-1:0]        r1_r, c1_r, r2_r, c2_r;
  logic signed [grars_pkg::ADDEND_W-1:0] x_r;
  logic [1:0]            corner_r;
  logic [RIW-1:0]        cr_r, i_r;
  logic [CIW-1:0]        cc_r, j_r;
  logic [FW-1:0]         rc_r;
  logic [SW-1:0]         xc_r, xr_r, xrc_r;
  logic [3:0][SW-1:0]    s_r;
  logic [2:0]            step_r;
  logic [HW+FW-1:0]      prod_r;
  logic [TW-1:0]         acc_r;
  logic [TW-1:0]         res_total_r;
  logic                  res_status_r;
  logic [TW-1:0]         out_total_r;
  logic                  out_status_r;

  // ram
  logic          mem_we;
  logic [AW-1:0] mem_waddr, node_addr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  logic [3:0][SW-1:0] rd_lanes, coef_lanes, sum_lanes;

  // decode of the item being taken
  logic in_fire, in_ok, out_load, last_corner, psign;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_ok    = (in_row_low <= in_row_high) && (in_row_high <= rows_r)
                 && (in_col_low <= in_col_high) && (in_col_high <= cols_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign last_corner = (corner_r == 2'd3);
  assign psign       = corner_r[1] ^ corner_r[0];

  // current corner point and its signed addend
  logic [RIW-1:0] corner_row;
  logic [CIW-1:0] corner_col;
  logic signed [XW-1:0] x33;
  assign corner_row = RIW'(corner_r[1] ? r2_r : r1_r);
  assign corner_col = CIW'(corner_r[0] ? c2_r : c1_r);
  assign x33 = psign ? -XW'(x_r) : XW'(x_r);

  // corner coefficient products
  logic signed [PXW-1:0] p_xc, p_xr, p_xrc;
  assign p_xc  = x33 * $signed({1'b0, corner_col});
  assign p_xr  = x33 * $signed({1'b0, corner_row});
  assign p_xrc = x33 * $signed({1'b0, rc_r});

  // tree index stepping
  logic [RIW-1:0] i_low, i_up, i_dn;
  logic [CIW-1:0] j_low, j_up, j_dn;
  assign i_low = i_r & (~i_r + RIW'(1));
  assign j_low = j_r & (~j_r + CIW'(1));
  assign i_up  = i_r + i_low;
  assign j_up  = j_r + j_low;
  assign i_dn  = i_r - i_low;
  assign j_dn  = j_r - j_low;

  // node address: (i-1) * MAX_COLS + (j-1)
  assign node_addr = AW'(i_r - RIW'(1)) * AW'(MAX_COLS) + AW'(j_r - CIW'(1));

  // lanes: plain, column, row, both
  assign rd_lanes   = mem_rdata;
  assign coef_lanes = {xrc_r, xr_r, xc_r, SW'(x33)};
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_lanes[k] = rd_lanes[k] + coef_lanes[k];
    end
  end

  // write port select
  assign mem_we    = (state_r == S_CLR) || (state_r == S_AWR);
  assign mem_waddr = (state_r == S_CLR) ? clr_addr_r : node_addr;
  assign mem_wdata = (state_r == S_CLR) ? '0 : MW'(sum_lanes);

  grars_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (node_addr),
    .rd_data (mem_rdata)
  );

  // prefix weighting: one 32-bit slice times a row/column factor per step
  logic [TW-1:0]      s_wide;
  logic [HW-1:0]      half;
  logic [FW-1:0]      factor;
  logic [HW+FW-1:0]   p_sum;
  logic [TW-1:0]      term, acc_step, acc_fin, s3_wide;
  logic               term_neg;
  always_comb begin
    case (step_r[2:1])
      2'd0:    s_wide = TW'(s_r[0]);
      2'd1:    s_wide = TW'(s_r[1]);
      default: s_wide = TW'(s_r[2]);
    endcase
    case (step_r[2:1])
      2'd0:    factor = rc_r;
      2'd1:    factor = FW'(cr_r);
      default: factor = FW'(cc_r);
    endcase
  end
  assign half     = step_r[0] ? s_wide[TW-1:HW] : s_wide[HW-1:0];
  assign p_sum    = half * factor;
  assign term     = step_r[0] ? {prod_r[HW-1:0], {HW{1'b0}}} : TW'(prod_r);
  assign term_neg = psign ^ (step_r[2] | step_r[1]);
  assign acc_step = term_neg ? acc_r - term : acc_r + term;
  assign s3_wide  = TW'(s_r[3]);
  assign acc_fin  = psign ? acc_r - s3_wide : acc_r + s3_wide;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = clr_item_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == grars_pkg::FN_CLEAR) state_nxt = S_CLR;
          else if ((in_func == grars_pkg::FN_ADD || in_func == grars_pkg::FN_SUM)
                   && in_ok) state_nxt = S_CPREP;
          else state_nxt = S_DONE;
        end
      end
      S_CPREP: begin
        if (!is_sum_r) state_nxt = S_CMUL;
        else if (corner_row == '0 || corner_col == '0) state_nxt = S_MUL;
        else state_nxt = S_PRD;
      end
      S_CMUL: begin
        if (i_r > ROW_LIM || j_r > COL_LIM) state_nxt = last_corner ? S_DONE : S_CPREP;
        else state_nxt = S_ARD;
      end
      S_ARD: state_nxt = S_AWR;
      S_AWR: begin
        if (j_up <= COL_LIM || i_up <= ROW_LIM) state_nxt = S_ARD;
        else state_nxt = last_corner ? S_DONE : S_CPREP;
      end
      S_PRD: state_nxt = S_PACC;
      S_PACC: begin
        if (j_dn != '0 || i_dn != '0) state_nxt = S_PRD;
        else state_nxt = S_MUL;
      end
      S_MUL:  state_nxt = S_MACC;
      S_MACC: state_nxt = (step_r == 3'd5) ? S_FIN : S_MUL;
      S_FIN:  state_nxt = last_corner ? S_DONE : S_CPREP;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // clearing sweep
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + AW'(1);
      else clr_addr_r <= '0;
      if (in_fire) clr_item_r <= 1'b1;
      // configuration writes, clamped to the supported range
      if (cfg_we) begin
        unique case (cfg_index)
          grars_pkg::REG_ROWS: begin
            if (cfg_wdata == '0) rows_r <= CDW'(1);
            else if (int'(cfg_wdata) > MAX_ROWS) rows_r <= CDW'(MAX_ROWS);
            else rows_r <= cfg_wdata;
          end
          grars_pkg::REG_COLS: begin
            if (cfg_wdata == '0) cols_r <= CDW'(1);
            else if (int'(cfg_wdata) > MAX_COLS) cols_r <= CDW'(MAX_COLS);
            else cols_r <= cfg_wdata;
          end
          default: ;
        endcase
      end
      // output register
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r  <= res_total_r;
      out_status_r <= res_status_r;
    end
    case (state_r)
      S_IDLE: begin
        r1_r         <= in_row_low;
        c1_r         <= in_col_low;
        r2_r         <= in_row_high;
        c2_r         <= in_col_high;
        x_r          <= in_addend;
        is_sum_r     <= (in_func == grars_pkg::FN_SUM);
        corner_r     <= 2'd0;
        acc_r        <= '0;
        res_total_r  <= '0;
        res_status_r <= (in_func != grars_pkg::FN_CLEAR) && !(in_ok &&
                        (in_func == grars_pkg::FN_ADD || in_func == grars_pkg::FN_SUM));
      end
      S_CPREP: begin
        cr_r   <= corner_row;
        cc_r   <= corner_col;
        rc_r   <= FW'(corner_row) * FW'(corner_col);
        xc_r   <= SW'(p_xc);
        xr_r   <= SW'(p_xr);
        s_r    <= '0;
        step_r <= '0;
        if (is_sum_r) begin
          i_r <= corner_row;
          j_r <= corner_col;
        end else begin
          i_r <= corner_row + RIW'(1);
          j_r <= corner_col + CIW'(1);
        end
      end
      S_CMUL: begin
        xrc_r <= SW'(p_xrc);
        if (i_r > ROW_LIM || j_r > COL_LIM) corner_r <= corner_r + 2'd1;
      end
      S_AWR: begin
        if (j_up <= COL_LIM) begin
          j_r <= j_up;
        end else if (i_up <= ROW_LIM) begin
          i_r <= i_up;
          j_r <= cc_r + CIW'(1);
        end else begin
          corner_r <= corner_r + 2'd1;
        end
      end
      S_PACC: begin
        for (int k = 0; k < 4; k++) begin
          s_r[k] <= s_r[k] + rd_lanes[k];
        end
        if (j_dn != '0) begin
          j_r <= j_dn;
        end else begin
          i_r <= i_dn;
          j_r <= cc_r;
        end
      end
      S_MUL: prod_r <= p_sum;
      S_MACC: begin
        acc_r  <= acc_step;
        step_r <= step_r + 3'd1;
      end
      S_FIN: begin
        acc_r       <= acc_fin;
        corner_r    <= corner_r + 2'd1;
        res_total_r <= TW'($signed(acc_fin[SW-1:0]));
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_total  = out_total_r;
  assign out_status = out_status_r;

  // checks
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready) else $error("item taken during clearing sweep");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || state_r == S_AWR)) else $error("stray ram write");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_total == '0)) else $error("rejected item with total");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE)) else $error("result without completion");

endmodule
